FILE: rtl/monotone_truth_table_flip_tracker_core_macros.svh
// assertion macros shared by the flip tracker modules
// no dependencies; included by the files that carry assertions
`ifndef MONOTONE_TRUTH_TABLE_FLIP_TRACKER_CORE_MACROS_SVH
`define MONOTONE_TRUTH_TABLE_FLIP_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MTFT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MTFT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mtft_pkg.sv
// shared types, constants and helpers of the flip tracker
// no dependencies; imported by the datapath, the controller and the top module
package mtft_pkg;

    // cube size and derived widths
    localparam int DIM       = 9;
    localparam int NPTS      = 1 << DIM;
    localparam int ADDR_W    = DIM;
    localparam int CNT_W     = DIM + 1;
    localparam int K_W       = (DIM > 1) ? $clog2(DIM) : 1;

    // fixed field widths
    localparam int IDX_W     = 9;
    localparam int CNT_OUT_W = 10;
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int CNT_EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    // command codes
    localparam logic CMD_TOGGLE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] point_index;
        logic             set_value;
    } req_t;

    typedef struct packed {
        logic                 new_value;
        logic [CNT_OUT_W-1:0] ones_count;
        logic [CNT_OUT_W-1:0] flippable_count;
        logic                 point_flippable;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic load;
        logic own_rd;
        logic own_write;
        logic nb_step;
        logic vtx_finish;
        logic res_rd;
        logic res_load;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic k_last;
        logic v_last;
    } sts_t;

    // index field to cube address, masked or zero extended
    function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] pi);
        logic [IDX_EXT_W-1:0] ext;
        ext = IDX_EXT_W'(pi);
        return ext[ADDR_W-1:0];
    endfunction

    // internal total to its low result field bits
    function automatic logic [CNT_OUT_W-1:0] cnt_to_field(input logic [CNT_W-1:0] c);
        logic [CNT_EXT_W-1:0] ext;
        ext = CNT_EXT_W'(c);
        return ext[CNT_OUT_W-1:0];
    endfunction

endpackage

FILE: rtl/mtft_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mtft_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mtft_dp.sv
// datapath: truth table and flippable map rams, counters, totals, result register
// depends on mtft_pkg, mtft_ram and the assertion macro header
`include "monotone_truth_table_flip_tracker_core_macros.svh"

module mtft_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  mtft_pkg::req_t req,
    input  mtft_pkg::ctl_t ctl,
    output mtft_pkg::sts_t sts,
    output mtft_pkg::rsp_t rsp
);
    import mtft_pkg::*;

    // item payload
    logic              cmd_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              val_reg;
    logic              newval_reg;

    // sequencing counters and accumulators
    logic [ADDR_W-1:0] vcnt_reg, vcnt_next;
    logic [K_W-1:0]    kcnt_reg, kcnt_next;
    logic              acc_reg, acc_next;
    logic              nb_bit_reg;
    logic [CNT_W-1:0]  ones_reg, ones_next;
    logic [CNT_W-1:0]  flip_reg, flip_next;
    rsp_t              rsp_reg;

    // ram ports
    logic              tt_we, tt_wdata, tt_rdata;
    logic [ADDR_W-1:0] tt_waddr, tt_raddr;
    logic              fm_we, fm_wdata, fm_rdata;
    logic [ADDR_W-1:0] fm_waddr, fm_raddr;

    // derived addresses and bits
    logic [ADDR_W-1:0] vtx;
    logic [ADDR_W-1:0] nb_addr;
    logic              nb_ok;
    logic              flip_now;
    logic              own_new;

    // current vertex: sweep address for set, neighbor of the index for toggle
    assign vtx     = (cmd_reg == CMD_SET) ? vcnt_reg : (idx_reg ^ (ADDR_W'(1) << vcnt_reg));
    assign nb_addr = vtx ^ (ADDR_W'(1) << kcnt_reg);

    // lower neighbor must hold 0, upper neighbor must hold 1
    assign nb_ok    = tt_rdata ^ nb_bit_reg;
    assign flip_now = acc_reg & nb_ok;
    assign own_new  = (cmd_reg == CMD_SET) ? val_reg : ~tt_rdata;

    // truth table ram ports
    assign tt_we    = ctl.clear_step | ctl.own_write;
    assign tt_waddr = ctl.clear_step ? vcnt_reg : idx_reg;
    assign tt_wdata = ctl.clear_step ? 1'b0 : own_new;
    assign tt_raddr = ctl.own_rd ? idx_reg : nb_addr;

    // flippable map ram ports; after clear only the all-ones vertex is set
    assign fm_we    = ctl.clear_step | ctl.vtx_finish;
    assign fm_waddr = ctl.clear_step ? vcnt_reg : vtx;
    assign fm_wdata = ctl.clear_step ? (vcnt_reg == ADDR_W'(NPTS - 1)) : flip_now;
    assign fm_raddr = ctl.res_rd ? idx_reg : vtx;

    mtft_ram #(.WIDTH(1), .DEPTH(NPTS)) u_tt_ram (
        .clk   (clk),
        .we    (tt_we),
        .waddr (tt_waddr),
        .wdata (tt_wdata),
        .raddr (tt_raddr),
        .rdata (tt_rdata)
    );

    mtft_ram #(.WIDTH(1), .DEPTH(NPTS)) u_fm_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    // status back to the controller
    always_comb
    begin
        sts.clear_last = (vcnt_reg == ADDR_W'(NPTS - 1));
        sts.k_last     = (kcnt_reg == K_W'(DIM - 1));
        sts.v_last     = (cmd_reg == CMD_SET) ? (vcnt_reg == ADDR_W'(NPTS - 1))
                                              : (vcnt_reg == ADDR_W'(DIM - 1));
    end

    // counter, accumulator and total updates
    always_comb
    begin
        vcnt_next = vcnt_reg;
        kcnt_next = kcnt_reg;
        acc_next  = acc_reg;
        ones_next = ones_reg;
        flip_next = flip_reg;
        if (ctl.load)
        begin
            vcnt_next = '0;
            kcnt_next = '0;
        end
        if (ctl.clear_step)
        begin
            vcnt_next = vcnt_reg + ADDR_W'(1);
        end
        if (ctl.own_write && (own_new != tt_rdata))
        begin
            ones_next = own_new ? (ones_reg + CNT_W'(1)) : (ones_reg - CNT_W'(1));
        end
        if (ctl.nb_step)
        begin
            kcnt_next = kcnt_reg + K_W'(1);
            acc_next  = (kcnt_reg == '0) ? 1'b1 : (acc_reg & nb_ok);
        end
        if (ctl.vtx_finish)
        begin
            kcnt_next = '0;
            vcnt_next = vcnt_reg + ADDR_W'(1);
            if (flip_now != fm_rdata)
            begin
                flip_next = flip_now ? (flip_reg + CNT_W'(1)) : (flip_reg - CNT_W'(1));
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
            kcnt_reg <= '0;
            acc_reg  <= 1'b1;
            ones_reg <= '0;
            flip_reg <= CNT_W'(1);
        end
        else
        begin
            vcnt_reg <= vcnt_next;
            kcnt_reg <= kcnt_next;
            acc_reg  <= acc_next;
            ones_reg <= ones_next;
            flip_reg <= flip_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req.cmd;
            idx_reg <= idx_to_addr(req.point_index);
            val_reg <= req.set_value;
        end
        if (ctl.own_write)
        begin
            newval_reg <= own_new;
        end
        if (ctl.nb_step)
        begin
            nb_bit_reg <= vtx[kcnt_reg];
        end
        if (ctl.res_load)
        begin
            rsp_reg.new_value       <= newval_reg;
            rsp_reg.ones_count      <= cnt_to_field(ones_reg);
            rsp_reg.flippable_count <= cnt_to_field(flip_reg);
            rsp_reg.point_flippable <= fm_rdata;
        end
    end

    assign rsp = rsp_reg;

    // checks; the neighbor counter has stepped past the last neighbor at finish
    `MTFT_ASSERT_IMP(a_ones_range, clk, rst_n, 1'b1, ones_reg <= CNT_W'(NPTS),
        "ones total beyond cube size")
    `MTFT_ASSERT_IMP(a_flip_range, clk, rst_n, 1'b1, flip_reg <= CNT_W'(NPTS),
        "flippable total beyond cube size")
    `MTFT_ASSERT_IMP(a_fin_after_all_nb, clk, rst_n, ctl.vtx_finish,
        kcnt_reg == K_W'(DIM), "vertex finished before all neighbors were read")

endmodule

FILE: rtl/mtft_ctrl.sv
// controller: state machine that sequences clear, own update, neighbour scan and result
// depends on mtft_pkg and the assertion macro header
`include "monotone_truth_table_flip_tracker_core_macros.svh"

module mtft_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  mtft_pkg::sts_t sts,
    output mtft_pkg::ctl_t ctl
);
    import mtft_pkg::*;

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        RD_OWN,
        OWN,
        NB,
        FIN,
        RES_RD,
        RES
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = RD_OWN;
                end
            end
            RD_OWN:
            begin
                ctl.own_rd = 1'b1;
                state_next = OWN;
            end
            OWN:
            begin
                ctl.own_write = 1'b1;
                state_next    = NB;
            end
            NB:
            begin
                ctl.nb_step = 1'b1;
                if (sts.k_last)
                begin
                    state_next = FIN;
                end
            end
            FIN:
            begin
                ctl.vtx_finish = 1'b1;
                state_next     = sts.v_last ? RES_RD : NB;
            end
            RES_RD:
            begin
                ctl.res_rd = 1'b1;
                state_next = RES;
            end
            RES:
            begin
                ctl.res_rd = 1'b1;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // result slot occupancy
    always_comb
    begin
        if (ctl.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != IDLE);
    assign rsp_valid = rsp_valid_reg;

    // checks
    `MTFT_ASSERT_NXT(a_accept_starts_item, clk, rst_n, req_valid && !req_stall,
        state_reg == RD_OWN, "accepted item did not start the own-point read")
    `MTFT_ASSERT_IMP(a_load_into_free_slot, clk, rst_n, ctl.res_load,
        !rsp_valid_reg || !rsp_stall, "result loaded over an undelivered result")
    `MTFT_ASSERT_NXT(a_clear_once, clk, rst_n, state_reg != CLEAR,
        state_reg != CLEAR, "clearing pass entered again after it finished")

endmodule

FILE: rtl/monotone_truth_table_flip_tracker_core.sv
// Flip tracker for a Boolean function on a DIM-dimensional cube (DIM = 9, 512 points).
// After reset a clearing pass writes the truth table and the flippable map into their
// rams; req_stall stays high until it ends. Items are then handled one at a time: a
// toggle re-evaluates the DIM neighbours of its point and a set re-evaluates all 512
// points. The time per item is set by the single read port of the truth table ram,
// which delivers one neighbour value per cycle, so every re-evaluated point costs DIM
// reads plus one map update. A finished result sits in an output register, and the
// next item is accepted while it waits to be taken.
// depends on mtft_pkg, mtft_ctrl and mtft_dp
module monotone_truth_table_flip_tracker_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mtft_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mtft_pkg::rsp_t rsp
);
    import mtft_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // sequencing
    mtft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // storage and arithmetic
    mtft_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
